>>> hw/rtl/seen_address_novelty_table_assert.svh
// Assertion macros for the seen address novelty table.
// Included by the modules that check their own logic; needs clk and rst in scope.
`ifndef SEEN_ADDRESS_NOVELTY_TABLE_ASSERT_SVH
`define SEEN_ADDRESS_NOVELTY_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SNT_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("snt assertion failed");
`define SNT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("snt assertion failed");
`else
`define SNT_ASSERT_IMPLIES(label, ante, cons)
`define SNT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/snt_pkg.sv
// Shared constants, codes and helper functions of the seen address novelty table.
// No dependencies; used by the channel interfaces and the top level.
package snt_pkg;

  localparam int BLE_DEPTH   = 256;
  localparam int WIFI_DEPTH  = 256;
  localparam int PROBE_DEPTH = 512;

  localparam int ADDR_W  = 48;
  localparam int COUNT_W = 10;
  localparam int SRC_W   = 2;

  localparam int MAX_DEPTH   = (BLE_DEPTH > WIFI_DEPTH) ?
                               ((BLE_DEPTH > PROBE_DEPTH) ? BLE_DEPTH : PROBE_DEPTH) :
                               ((WIFI_DEPTH > PROBE_DEPTH) ? WIFI_DEPTH : PROBE_DEPTH);
  localparam int TOTAL_DEPTH = BLE_DEPTH + WIFI_DEPTH + PROBE_DEPTH;
  localparam int CNT_W       = $clog2(MAX_DEPTH + 1);
  localparam int MEM_AW      = $clog2(TOTAL_DEPTH);

  localparam logic KIND_OBSERVE = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [SRC_W-1:0] SRC_BLE   = 2'd0;
  localparam logic [SRC_W-1:0] SRC_WIFI  = 2'd1;
  localparam logic [SRC_W-1:0] SRC_PROBE = 2'd2;

  // Capacity of a source table; zero for the unused code.
  function automatic logic [CNT_W-1:0] depth_of(input logic [SRC_W-1:0] src);
    logic [CNT_W-1:0] d;
    case (src)
      SRC_BLE:   d = CNT_W'(BLE_DEPTH);
      SRC_WIFI:  d = CNT_W'(WIFI_DEPTH);
      SRC_PROBE: d = CNT_W'(PROBE_DEPTH);
      default:   d = '0;
    endcase
    return d;
  endfunction

  // First memory word of a source table; the tables sit back to back.
  function automatic logic [MEM_AW-1:0] base_of(input logic [SRC_W-1:0] src);
    logic [MEM_AW-1:0] b;
    case (src)
      SRC_WIFI:  b = MEM_AW'(BLE_DEPTH);
      SRC_PROBE: b = MEM_AW'(BLE_DEPTH + WIFI_DEPTH);
      default:   b = '0;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/snt_channels.sv
// Valid/ready channel interfaces of the seen address novelty table.
// Depends on snt_pkg for field widths.
interface snt_obs_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [snt_pkg::SRC_W-1:0]  src;
  logic [snt_pkg::ADDR_W-1:0] address;

  modport source (output valid, kind, src, address, input ready);
  modport sink (input valid, kind, src, address, output ready);
endinterface

interface snt_res_if;
  logic                        valid;
  logic                        ready;
  logic                        is_new;
  logic                        alert;
  logic                        table_full;
  logic [snt_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, is_new, alert, table_full, entry_count, input ready);
  modport sink (input valid, is_new, alert, table_full, entry_count, output ready);
endinterface

>>> hw/rtl/seen_address_novelty_table.sv
// Top level of the seen address novelty table.
// Depends on snt_pkg, snt_channels.sv, snt_ram and seen_address_novelty_table_assert.svh.
//
// Usage:
//   obs carries one item per scan event: kind (observe or end baseline),
//   source (BLE, Wi-Fi access point, probe request) and the 48-bit address.
//   res returns exactly one item per obs item, in order: is_new, alert,
//   table_full and the entry count of the addressed source table.
// Timing:
//   One item is worked at a time. An observe item searches its table in one
//   shared memory, one entry per cycle, pipelined against the registered read.
//   End-baseline items, the unused source code and empty tables skip the
//   search and go straight to the finish state.
//   The next item is accepted the cycle after the result is registered.
// Reset:
//   rst clears the fill counts (all tables read as empty) and restarts the
//   learning period. Memory contents are not cleared: only words below a
//   fill count are ever compared.
// Stall:
//   The result sits in an output register. While it waits, the block keeps
//   accepting and searching the next item; that item's result waits in the
//   finish state (no memory write, no count update) until the register frees.
`include "seen_address_novelty_table_assert.svh"

module seen_address_novelty_table (
  input logic       clk,
  input logic       rst,
  snt_obs_if.sink   obs,
  snt_res_if.source res
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Item under work
  logic                             kind;
  logic [snt_pkg::SRC_W-1:0]        src;
  logic [snt_pkg::ADDR_W-1:0]       addr;
  logic                             found;
  logic [snt_pkg::CNT_W-1:0]        cmp_idx;

  // Fill counts and learning flag
  logic [snt_pkg::CNT_W-1:0] fill_ble;
  logic [snt_pkg::CNT_W-1:0] fill_wifi;
  logic [snt_pkg::CNT_W-1:0] fill_probe;
  logic                      learning;

  // Memory port
  logic                       wr_en;
  logic [snt_pkg::MEM_AW-1:0] wr_addr;
  logic [snt_pkg::MEM_AW-1:0] rd_addr;
  logic [snt_pkg::ADDR_W-1:0] rd_data;

  logic                      obs_fire;
  logic                      res_free;
  logic [snt_pkg::CNT_W-1:0] cur_fill;
  logic [snt_pkg::CNT_W-1:0] obs_fill;
  logic [snt_pkg::CNT_W-1:0] cur_depth;
  logic                      src_ok;
  logic                      observe_ok;
  logic                      append;
  logic                      dropped;
  logic                      hit;
  logic                      last_cmp;
  logic [snt_pkg::CNT_W-1:0] count_after;

  function automatic logic [snt_pkg::CNT_W-1:0] fill_sel(
    input logic [snt_pkg::SRC_W-1:0] s,
    input logic [snt_pkg::CNT_W-1:0] fb,
    input logic [snt_pkg::CNT_W-1:0] fw,
    input logic [snt_pkg::CNT_W-1:0] fp
  );
    logic [snt_pkg::CNT_W-1:0] f;
    case (s)
      snt_pkg::SRC_BLE:   f = fb;
      snt_pkg::SRC_WIFI:  f = fw;
      snt_pkg::SRC_PROBE: f = fp;
      default:            f = '0;
    endcase
    return f;
  endfunction

  assign obs.ready = (state == ST_IDLE);
  assign obs_fire  = obs.valid && obs.ready;
  assign res_free  = !res.valid || res.ready;

  assign cur_fill  = fill_sel(src, fill_ble, fill_wifi, fill_probe);
  assign obs_fill  = fill_sel(obs.src, fill_ble, fill_wifi, fill_probe);
  assign cur_depth = snt_pkg::depth_of(src);
  assign src_ok    = (src == snt_pkg::SRC_BLE) || (src == snt_pkg::SRC_WIFI) ||
                     (src == snt_pkg::SRC_PROBE);

  // Decide append or drop once the search has run out
  assign observe_ok  = (kind == snt_pkg::KIND_OBSERVE) && src_ok && !found;
  assign append      = observe_ok && (cur_fill < cur_depth);
  assign dropped     = observe_ok && !(cur_fill < cur_depth);
  assign count_after = append ? (cur_fill + 1'b1) : cur_fill;

  assign hit      = (rd_data == addr);
  assign last_cmp = ((cmp_idx + 1'b1) == cur_fill);

  // Read address: entry 0 on accept, the following entry while scanning
  always_comb begin
    if (state == ST_IDLE) begin
      rd_addr = snt_pkg::base_of(obs.src);
    end else begin
      rd_addr = snt_pkg::base_of(src) + snt_pkg::MEM_AW'(cmp_idx + 1'b1);
    end
  end

  assign wr_en   = (state == ST_FINISH) && res_free && append;
  assign wr_addr = snt_pkg::base_of(src) + snt_pkg::MEM_AW'(cur_fill);

  snt_ram #(
    .WIDTH (snt_pkg::ADDR_W),
    .DEPTH (snt_pkg::TOTAL_DEPTH)
  ) u_table_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (addr),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (obs_fire) begin
          // End-baseline, unused source and empty table need no search
          if ((obs.kind == snt_pkg::KIND_END) ||
              (snt_pkg::depth_of(obs.src) == '0) || (obs_fill == '0)) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit || last_cmp) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_ble   <= '0;
      fill_wifi  <= '0;
      fill_probe <= '0;
      learning   <= 1'b1;
      res.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      if ((state == ST_FINISH) && res_free) begin
        res.valid <= 1'b1;
        if (kind == snt_pkg::KIND_END) begin
          learning <= 1'b0;
        end
        if (append) begin
          case (src)
            snt_pkg::SRC_BLE:   fill_ble   <= count_after;
            snt_pkg::SRC_WIFI:  fill_wifi  <= count_after;
            snt_pkg::SRC_PROBE: fill_probe <= count_after;
            default:            ;
          endcase
        end
      end
    end
  end

  // Item payload and search progress
  always_ff @(posedge clk) begin
    if (obs_fire) begin
      kind    <= obs.kind;
      src     <= obs.src;
      addr    <= obs.address;
      found   <= 1'b0;
      cmp_idx <= '0;
    end else if (state == ST_SCAN) begin
      if (hit) begin
        found <= 1'b1;
      end else if (!last_cmp) begin
        cmp_idx <= cmp_idx + 1'b1;
      end
    end
  end

  // Result register: load when the finish state can hand off
  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && res_free) begin
      res.is_new      <= append;
      res.alert       <= append && !learning;
      res.table_full  <= dropped;
      res.entry_count <= snt_pkg::COUNT_W'(count_after);
    end
  end

  `SNT_ASSERT_IMPLIES(a_fill_in_range, 1'b1,
    (fill_ble <= snt_pkg::CNT_W'(snt_pkg::BLE_DEPTH)) &&
    (fill_wifi <= snt_pkg::CNT_W'(snt_pkg::WIFI_DEPTH)) &&
    (fill_probe <= snt_pkg::CNT_W'(snt_pkg::PROBE_DEPTH)))
  `SNT_ASSERT_IMPLIES(a_write_only_finish, wr_en, (state == ST_FINISH) && !found)
  `SNT_ASSERT_NEXT(a_busy_after_accept, obs_fire, !obs.ready)
  `SNT_ASSERT_IMPLIES(a_result_consistent, res.valid,
    !(res.is_new && res.table_full) && (!res.alert || res.is_new))

endmodule

>>> hw/rtl/snt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module snt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
